>>> src/hlcr_pkg.sv
// Shared types, constants and helpers for the humidity level colour ramp.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hlcr_pkg;

    // Blink half period in ticks, colour depth of the ramp
    localparam int BLINK_HALF_TICKS = 25;
    localparam int COLOR_BITS       = 8;

    localparam int COLOR_MAX = (1 << COLOR_BITS) - 1;
    localparam int BLINK_W   = $clog2(BLINK_HALF_TICKS + 1);

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DRY_THRESHOLD        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DAMP_THRESHOLD       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HYST_BAND            = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STALE_LIMIT_MS       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_REMOTE_TIMEOUT_TICKS = 3'd4;

    // Remote command codes
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_CUSTOM = 2'd1;
    localparam logic [1:0] ACT_AUTO   = 2'd2;

    typedef enum logic [1:0] {
        LVL_DRY  = 2'd0,
        LVL_OPT  = 2'd1,
        LVL_DAMP = 2'd2,
        LVL_ERR  = 2'd3
    } t_level;

    typedef logic [COLOR_BITS-1:0] t_color;
    typedef t_color [0:2]          t_rgb;   // [0] red, [1] green, [2] blue

    typedef struct packed {
        logic [9:0]  humidity;
        logic [15:0] sensor_age_ms;
        logic [1:0]  action;
        logic [7:0]  cmd_red;
        logic [7:0]  cmd_green;
        logic [7:0]  cmd_blue;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic [1:0] humidity_level;
        logic       remote_mode;
    } t_out_beat;

    typedef struct packed {
        logic [9:0]  dry_threshold;
        logic [9:0]  damp_threshold;
        logic [7:0]  hyst_band;
        logic [15:0] stale_limit_ms;
        logic [15:0] remote_timeout_ticks;
    } t_cfg;

    // 8-bit palette entry rescaled to the ramp depth (elaboration only)
    function automatic t_color scale8(int v);
        int s;
        s = v * COLOR_MAX / 255;
        return t_color'(s);
    endfunction

    localparam t_rgb PALETTE [4] = '{
        '{scale8(255), scale8(120), scale8(0)},
        '{scale8(0),   scale8(255), scale8(100)},
        '{scale8(0),   scale8(50),  scale8(255)},
        '{scale8(255), scale8(0),   scale8(0)}
    };

    function automatic t_color step_toward(t_color cur, t_color tgt);
        t_color r;
        if (cur < tgt) begin
            r = cur + t_color'(1);
        end else if (cur > tgt) begin
            r = cur - t_color'(1);
        end else begin
            r = cur;
        end
        return r;
    endfunction

    // Ramp colour to an 8-bit drive field
    function automatic logic [7:0] to_drive(t_color c);
        logic [31:0] w;
        w = 32'(c);
        return w[7:0];
    endfunction

    // Command colour masked to the ramp depth
    function automatic t_color from_cmd(logic [7:0] v);
        logic [31:0] w;
        w = 32'(v) & 32'(COLOR_MAX);
        return w[COLOR_BITS-1:0];
    endfunction

endpackage

>>> src/humidity_level_color_ramp.sv
// Top level of the humidity level colour ramp: input and result registers,
// handshake, config bank and tick state. Depends on hlcr_pkg, hlcr_cfg_regs, hlcr_state.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------
//   in      | to block  | i_in_valid / o_in_stall   | i_in  (t_in_beat)
//   out     | from block| o_out_valid / i_out_stall | o_out (t_out_beat)
//   cfg     | to block  | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One beat per cycle sustained while i_out_stall is low. A beat taken sits in the input
// register, passes the level/ramp logic into the result register and can then be
// taken from o_out.
// Synchronous active-low reset restores register defaults and state.
// A stalled result holds in the output register while the input register keeps
// one more beat; o_in_stall rises only when both are full.
`timescale 1ns / 1ps

module humidity_level_color_ramp import hlcr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_beat               i_in,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_beat              o_out,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic      r_in_valid;
    t_in_beat  r_in;
    logic      r_out_valid;
    t_out_beat r_out;
    logic      adv;
    t_cfg      cfg;
    t_out_beat result;

    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= result;
        end
    end

    hlcr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    hlcr_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_beat   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> src/hlcr_cfg_regs.sv
// Configuration register bank of the humidity level colour ramp.
// Depends on hlcr_pkg.
`timescale 1ns / 1ps

module hlcr_cfg_regs import hlcr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dry_threshold        <= 10'd400;
            r_cfg.damp_threshold       <= 10'd700;
            r_cfg.hyst_band            <= 8'd20;
            r_cfg.stale_limit_ms       <= 16'd5000;
            r_cfg.remote_timeout_ticks <= 16'd500;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DRY_THRESHOLD:        r_cfg.dry_threshold        <= i_cfg_data[9:0];
                CFG_DAMP_THRESHOLD:       r_cfg.damp_threshold       <= i_cfg_data[9:0];
                CFG_HYST_BAND:            r_cfg.hyst_band            <= i_cfg_data[7:0];
                CFG_STALE_LIMIT_MS:       r_cfg.stale_limit_ms       <= i_cfg_data;
                CFG_REMOTE_TIMEOUT_TICKS: r_cfg.remote_timeout_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/hlcr_state.sv
// Tick state of the colour ramp: level machine, remote override, blink and
// ramped colour, with the next-state logic for one beat. Depends on hlcr_pkg.
`timescale 1ns / 1ps

module hlcr_state import hlcr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  t_in_beat  i_beat,
    input  t_cfg      i_cfg,
    output t_out_beat o_result
);

    t_level             r_level,          n_level;
    t_rgb               r_current,        n_current;
    t_rgb               r_target,         n_target;
    logic               r_remote_active,  n_remote_active;
    logic [15:0]        r_remote_elapsed, n_remote_elapsed;
    logic               r_blink_on,       n_blink_on;
    logic [BLINK_W-1:0] r_blink_count,    n_blink_count;

    logic               act_custom;
    logic               act_auto;
    t_rgb               tgt_a;
    t_rgb               cur_a;
    t_rgb               shown;
    logic               ra_a;
    logic [15:0]        el_a;
    logic               in_force;
    logic [10:0]        hum_m;
    logic [BLINK_W-1:0] cnt_inc;

    always_comb begin
        act_custom = (i_beat.action == ACT_CUSTOM);
        act_auto   = (i_beat.action == ACT_AUTO);

        tgt_a = r_target;
        if (act_custom) begin
            tgt_a[0] = from_cmd(i_beat.cmd_red);
            tgt_a[1] = from_cmd(i_beat.cmd_green);
            tgt_a[2] = from_cmd(i_beat.cmd_blue);
        end
        ra_a = act_custom ? 1'b1 : (act_auto ? 1'b0 : r_remote_active);
        el_a = act_custom ? 16'd0 : r_remote_elapsed;

        in_force = ra_a && (el_a < i_cfg.remote_timeout_ticks);
        // timeout tick clears the ramp before the level machine runs
        cur_a    = (ra_a && !in_force) ? '0 : r_current;

        hum_m   = 11'(i_beat.humidity) + 11'(i_cfg.hyst_band);
        cnt_inc = r_blink_count + BLINK_W'(1);

        n_level          = r_level;
        n_current        = cur_a;
        n_target         = tgt_a;
        n_remote_active  = 1'b0;
        n_remote_elapsed = el_a;
        n_blink_on       = r_blink_on;
        n_blink_count    = r_blink_count;
        shown            = '0;

        if (in_force) begin
            for (int i = 0; i < 3; i++) begin
                n_current[i] = step_toward(cur_a[i], tgt_a[i]);
            end
            n_remote_active  = 1'b1;
            n_remote_elapsed = (el_a == 16'hFFFF) ? el_a : el_a + 16'd1;
            shown            = n_current;
        end else begin
            if (i_beat.sensor_age_ms > i_cfg.stale_limit_ms) begin
                n_level = LVL_ERR;
            end else begin
                case (r_level)
                    LVL_DRY: begin
                        if (i_beat.humidity >= i_cfg.dry_threshold) n_level = LVL_OPT;
                    end
                    LVL_OPT: begin
                        // hum < thr - margin, never met when the bound is negative
                        if (hum_m < 11'(i_cfg.dry_threshold)) begin
                            n_level = LVL_DRY;
                        end else if (i_beat.humidity >= i_cfg.damp_threshold) begin
                            n_level = LVL_DAMP;
                        end
                    end
                    LVL_DAMP: begin
                        if (hum_m < 11'(i_cfg.damp_threshold)) n_level = LVL_OPT;
                    end
                    default: n_level = LVL_OPT;   // first fresh tick after error
                endcase
            end

            n_target = PALETTE[n_level];

            if (n_level != LVL_ERR) begin
                for (int i = 0; i < 3; i++) begin
                    n_current[i] = step_toward(cur_a[i], n_target[i]);
                end
                shown = n_current;
            end else begin
                n_blink_count = cnt_inc;
                if (32'(cnt_inc) >= BLINK_HALF_TICKS) begin
                    n_blink_on    = !r_blink_on;
                    n_blink_count = '0;
                end
                n_current = '0;
                shown     = n_blink_on ? n_target : '0;
            end
        end

        o_result.pixel_red      = to_drive(shown[0]);
        o_result.pixel_green    = to_drive(shown[1]);
        o_result.pixel_blue     = to_drive(shown[2]);
        o_result.humidity_level = n_level;
        o_result.remote_mode    = in_force;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level          <= LVL_OPT;
            r_current        <= '0;
            r_target         <= '0;
            r_remote_active  <= 1'b0;
            r_remote_elapsed <= '0;
            r_blink_on       <= 1'b0;
            r_blink_count    <= '0;
        end else if (i_adv) begin
            r_level          <= n_level;
            r_current        <= n_current;
            r_target         <= n_target;
            r_remote_active  <= n_remote_active;
            r_remote_elapsed <= n_remote_elapsed;
            r_blink_on       <= n_blink_on;
            r_blink_count    <= n_blink_count;
        end
    end

endmodule

>>> src/hlcr_checker.sv
// Port-level checks for the humidity level colour ramp, bound to the top level.
// Depends on hlcr_pkg and humidity_level_color_ramp.
`timescale 1ns / 1ps

module hlcr_checker import hlcr_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input t_out_beat              o_out,
    input logic                   i_cfg_we,
    input logic [CFG_INDEX_W-1:0] i_cfg_index,
    input logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_out_beat r_prev;
    logic      r_prev_ok;
    logic      r_timeout_zero;
    logic      out_take;
    logic      ramp_pair;

    assign out_take  = o_out_valid && !i_out_stall;
    // both beats in a level colour that is not error: shown colour is the ramp;
    // a zero timeout lets a custom command clear the ramp without remote mode
    assign ramp_pair = out_take && r_prev_ok && !o_out.remote_mode && !r_prev.remote_mode
                    && (o_out.humidity_level != LVL_ERR)
                    && (r_prev.humidity_level != LVL_ERR)
                    && !r_timeout_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_ok <= 1'b0;
        end else if (out_take) begin
            r_prev_ok <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_prev <= o_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_zero <= 1'b0;
        end else if (i_cfg_we && (i_cfg_index == CFG_REMOTE_TIMEOUT_TICKS)) begin
            r_timeout_zero <= (i_cfg_data == '0);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result beat changed or dropped");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while the result side is free");

    a_remote_freezes_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && r_prev_ok && o_out.remote_mode |->
            o_out.humidity_level == r_prev.humidity_level)
        else $error("level moved while remote colour in force");

    a_error_red_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.remote_mode && (o_out.humidity_level == LVL_ERR) |->
            (o_out.pixel_green == 8'd0) && (o_out.pixel_blue == 8'd0))
        else $error("error level shows a colour other than red");

    a_ramp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ramp_pair |->
            ((o_out.pixel_red == r_prev.pixel_red)
                || (o_out.pixel_red == r_prev.pixel_red + 8'd1)
                || (r_prev.pixel_red == o_out.pixel_red + 8'd1))
            && ((o_out.pixel_green == r_prev.pixel_green)
                || (o_out.pixel_green == r_prev.pixel_green + 8'd1)
                || (r_prev.pixel_green == o_out.pixel_green + 8'd1))
            && ((o_out.pixel_blue == r_prev.pixel_blue)
                || (o_out.pixel_blue == r_prev.pixel_blue + 8'd1)
                || (r_prev.pixel_blue == o_out.pixel_blue + 8'd1)))
        else $error("ramped colour jumped by more than one count");

endmodule

bind humidity_level_color_ramp hlcr_checker u_hlcr_checker (.*);

>>> verif/tb_top.sv
// Self-checking bench for humidity_level_color_ramp: a tick-level predictor
// and scoreboard plus handshake drivers. Depends on hlcr_pkg and the block.
`timescale 1ns / 1ps

module tb_top;
    import hlcr_pkg::*;

    // action 3 carries no command
    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    // 8-bit palette per level: dry, optimal, damp, error
    localparam int         LEVEL_HUE [4][3] = '{
        '{255, 120, 0}, '{0, 255, 100}, '{0, 50, 255}, '{255, 0, 0}
    };
    localparam int         HOLD_CYCLES    = 200;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         PHASE_TICKS    = 62;
    localparam int         DRAIN_SLACK    = 6;
    localparam int         MAX_REPORTS    = 40;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    t_in_beat               i_in;
    logic                   o_out_valid;
    logic                   i_out_stall;
    t_out_beat              o_out;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    humidity_level_color_ramp dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    class ramp_scoreboard;
        t_out_beat   pixel_due [$];
        int          errors;
        int          checked;
        int          dry_th;
        int          damp_th;
        int          margin;
        logic [15:0] stale_ms;
        logic [15:0] timeout_ticks;
        t_level      lvl;
        t_color      cur [3];
        t_color      tgt [3];
        bit          remote_on;
        logic [15:0] remote_ticks;
        bit          blink_lit;
        int          blink_ticks;

        function new();
            dry_th        = 400;
            damp_th       = 700;
            margin        = 20;
            stale_ms      = 16'd5000;
            timeout_ticks = 16'd500;
            lvl           = LVL_OPT;
            for (int i = 0; i < 3; i++) begin
                cur[i] = '0;
                tgt[i] = '0;
            end
            remote_on    = 1'b0;
            remote_ticks = '0;
            blink_lit    = 1'b0;
            blink_ticks  = 0;
            errors       = 0;
            checked      = 0;
        endfunction

        function void apply_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_DRY_THRESHOLD:        dry_th        = int'(d[9:0]);
                CFG_DAMP_THRESHOLD:       damp_th       = int'(d[9:0]);
                CFG_HYST_BAND:            margin        = int'(d[7:0]);
                CFG_STALE_LIMIT_MS:       stale_ms      = d;
                CFG_REMOTE_TIMEOUT_TICKS: timeout_ticks = d;
                default: ;
            endcase
        endfunction

        function void ramp_step();
            for (int i = 0; i < 3; i++) begin
                if (cur[i] < tgt[i]) begin
                    cur[i] = cur[i] + 1'b1;
                end else if (cur[i] > tgt[i]) begin
                    cur[i] = cur[i] - 1'b1;
                end
            end
        endfunction

        // one tick in, the pixel it shows queued
        function void note_tick(t_in_beat b);
            t_out_beat o;
            t_color    shown [3];
            bit        remote_shown;
            int        hum;

            hum          = int'(b.humidity);
            remote_shown = 1'b0;
            if (b.action == ACT_CUSTOM) begin
                remote_on    = 1'b1;
                remote_ticks = '0;
                tgt[0]       = t_color'(int'(b.cmd_red) & COLOR_MAX);
                tgt[1]       = t_color'(int'(b.cmd_green) & COLOR_MAX);
                tgt[2]       = t_color'(int'(b.cmd_blue) & COLOR_MAX);
            end else if (b.action == ACT_AUTO) begin
                remote_on = 1'b0;
            end

            if (remote_on) begin
                if (remote_ticks < timeout_ticks) begin
                    ramp_step();
                    if (remote_ticks != 16'hFFFF) remote_ticks = remote_ticks + 1'b1;
                    remote_shown = 1'b1;
                end else begin
                    // timed out: colour cleared, level machine runs this tick
                    remote_on = 1'b0;
                    for (int i = 0; i < 3; i++) cur[i] = '0;
                end
            end

            if (remote_shown) begin
                for (int i = 0; i < 3; i++) shown[i] = cur[i];
            end else begin
                if (b.sensor_age_ms > stale_ms) begin
                    lvl = LVL_ERR;
                end else begin
                    case (lvl)
                        LVL_DRY: begin
                            if (hum >= dry_th) lvl = LVL_OPT;
                        end
                        LVL_OPT: begin
                            if (hum < dry_th - margin) lvl = LVL_DRY;
                            else if (hum >= damp_th) lvl = LVL_DAMP;
                        end
                        LVL_DAMP: begin
                            if (hum < damp_th - margin) lvl = LVL_OPT;
                        end
                        default: lvl = LVL_OPT;
                    endcase
                end
                for (int i = 0; i < 3; i++) tgt[i] = t_color'(LEVEL_HUE[lvl][i] * COLOR_MAX / 255);
                if (lvl != LVL_ERR) begin
                    ramp_step();
                    for (int i = 0; i < 3; i++) shown[i] = cur[i];
                end else begin
                    blink_ticks++;
                    if (blink_ticks >= BLINK_HALF_TICKS) begin
                        blink_lit   = !blink_lit;
                        blink_ticks = 0;
                    end
                    for (int i = 0; i < 3; i++) begin
                        shown[i] = blink_lit ? tgt[i] : t_color'(0);
                        cur[i]   = '0;
                    end
                end
            end

            o.pixel_red      = 8'(shown[0]);
            o.pixel_green    = 8'(shown[1]);
            o.pixel_blue     = 8'(shown[2]);
            o.humidity_level = lvl;
            o.remote_mode    = remote_shown;
            pixel_due.push_back(o);
        endfunction

        task report_mismatch(string what, int got, int want);
            if (errors < MAX_REPORTS) begin
                $display("MISMATCH beat %0d %s: got %0d, want %0d", checked, what, got, want);
            end
            errors++;
        endtask

        task check_result(t_out_beat got);
            t_out_beat want;
            if (pixel_due.size() == 0) begin
                report_mismatch("result with none due", 1, 0);
            end else begin
                want = pixel_due.pop_front();
                if (got.pixel_red !== want.pixel_red)
                    report_mismatch("pixel_red", got.pixel_red, want.pixel_red);
                if (got.pixel_green !== want.pixel_green)
                    report_mismatch("pixel_green", got.pixel_green, want.pixel_green);
                if (got.pixel_blue !== want.pixel_blue)
                    report_mismatch("pixel_blue", got.pixel_blue, want.pixel_blue);
                if (got.humidity_level !== want.humidity_level)
                    report_mismatch("humidity_level", got.humidity_level, want.humidity_level);
                if (got.remote_mode !== want.remote_mode)
                    report_mismatch("remote_mode", got.remote_mode, want.remote_mode);
                checked++;
            end
        endtask

        task close_out();
            if (pixel_due.size() != 0) report_mismatch("results never seen", pixel_due.size(), 0);
        endtask
    endclass

    ramp_scoreboard sb;
    bit             hold_req    = 1'b0;
    int             idle_cycles = 0;
    int             burst_left  = 0;
    int             hum_walk    = 500;
    int             stale_run   = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // beat monitor: predict on input accept, check on output accept
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_tick(i_in);
            if (o_out_valid && !i_out_stall) sb.check_result(o_out);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    // receiver: stall pattern changes at random intervals; long hold on request
    initial begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 120);
                end
                left--;
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 7) == 0);
                    2: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= ~i_out_stall;
                endcase
            end
        end
    end

    function automatic t_in_beat mk_tick(int hum, int age, logic [1:0] act, int r, int g, int b);
        t_in_beat t;
        t.humidity      = 10'(hum);
        t.sensor_age_ms = 16'(age);
        t.action        = act;
        t.cmd_red       = 8'(r);
        t.cmd_green     = 8'(g);
        t.cmd_blue      = 8'(b);
        return t;
    endfunction

    // humidity wanders, with jumps onto thresholds and fall-back bounds;
    // stale runs are mostly long enough to see the blink toggle
    function automatic t_in_beat next_tick();
        int         th;
        int         age;
        int         pick;
        logic [1:0] act;

        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            th = $urandom_range(0, 1) ? sb.dry_th : sb.damp_th;
            if ($urandom_range(0, 1)) th = th - sb.margin;
            hum_walk = th + int'($urandom_range(0, 6)) - 3;
        end else if (pick < 15) begin
            hum_walk = $urandom_range(0, 1000);
        end else if (pick < 18) begin
            hum_walk = $urandom_range(0, 1) ? 1000 : 0;
        end else begin
            hum_walk = hum_walk + int'($urandom_range(0, 40)) - 20;
        end
        if (hum_walk < 0) hum_walk = 0;
        if (hum_walk > 1000) hum_walk = 1000;

        if (stale_run == 0 && sb.stale_ms != 16'hFFFF && $urandom_range(0, 39) == 0)
            stale_run = $urandom_range(20, 60);
        if (stale_run > 0) begin
            stale_run--;
            age = ($urandom_range(0, 3) == 0) ? 65535
                                              : $urandom_range(int'(sb.stale_ms) + 1, 65535);
        end else begin
            age = ($urandom_range(0, 7) == 0) ? int'(sb.stale_ms)
                                              : $urandom_range(0, int'(sb.stale_ms));
        end

        pick = $urandom_range(0, 99);
        if (pick < 5) act = ACT_CUSTOM;
        else if (pick < 8) act = ACT_AUTO;
        else if (pick < 10) act = ACT_UNUSED;
        else act = ACT_NONE;
        return mk_tick(hum_walk, age, act, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255));
    endfunction

    // sender: bursts of random length, random gaps between them
    task automatic send_tick(input t_in_beat b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in       <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (sb.pixel_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic program_regs(input t_cfg c);
        logic [CFG_DATA_W-1:0]  vals [5];
        logic [CFG_INDEX_W-1:0] idx [5];
        vals = '{16'(c.dry_threshold), 16'(c.damp_threshold), 16'(c.hyst_band),
                 c.stale_limit_ms, c.remote_timeout_ticks};
        idx  = '{CFG_DRY_THRESHOLD, CFG_DAMP_THRESHOLD, CFG_HYST_BAND,
                 CFG_STALE_LIMIT_MS, CFG_REMOTE_TIMEOUT_TICKS};
        for (int k = 0; k < 5; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            sb.apply_cfg(idx[k], vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_in_beat directed [$];
        t_cfg     c;

        sb = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: 400 / 700 / 20, stale 5000, timeout 500
        directed.push_back(mk_tick(0, 0, ACT_NONE, 0, 0, 0));
        directed.push_back(mk_tick(1000, 0, ACT_NONE, 0, 0, 0));
        directed.push_back(mk_tick(1000, 0, ACT_NONE, 0, 0, 0));
        directed.push_back(mk_tick(680, 0, ACT_NONE, 0, 0, 0));   // on the damp bound
        directed.push_back(mk_tick(679, 0, ACT_NONE, 0, 0, 0));
        directed.push_back(mk_tick(380, 0, ACT_NONE, 0, 0, 0));   // on the dry bound
        directed.push_back(mk_tick(379, 0, ACT_NONE, 0, 0, 0));
        directed.push_back(mk_tick(399, 0, ACT_NONE, 0, 0, 0));
        directed.push_back(mk_tick(400, 0, ACT_NONE, 0, 0, 0));
        directed.push_back(mk_tick(0, 5000, ACT_NONE, 0, 0, 0));  // age at the limit is fresh
        directed.push_back(mk_tick(0, 5001, ACT_NONE, 0, 0, 0));
        directed.push_back(mk_tick(1000, 65535, ACT_NONE, 255, 255, 255));
        directed.push_back(mk_tick(0, 0, ACT_NONE, 0, 0, 0));     // leave error: straight to optimal
        directed.push_back(mk_tick(500, 0, ACT_UNUSED, 255, 255, 255));
        directed.push_back(mk_tick(500, 0, ACT_CUSTOM, 255, 0, 255));
        directed.push_back(mk_tick(1000, 65535, ACT_NONE, 0, 0, 0));
        directed.push_back(mk_tick(0, 0, ACT_CUSTOM, 0, 255, 0));
        directed.push_back(mk_tick(0, 0, ACT_NONE, 170, 85, 170));
        directed.push_back(mk_tick(0, 0, ACT_AUTO, 0, 0, 0));     // colour kept on exit
        directed.push_back(mk_tick(1000, 0, ACT_NONE, 0, 0, 0));
        directed.push_back(mk_tick(1000, 65535, ACT_CUSTOM, 85, 170, 85));
        directed.push_back(mk_tick(700, 0, ACT_AUTO, 255, 255, 255));
        foreach (directed[k]) send_tick(directed[k]);
        for (int n = 0; n < PHASE_TICKS; n++) send_tick(next_tick());
        drain_results();

        for (int p = 1; p < 8; p++) begin
            case (p)
                1: c = '{10'd0, 10'd0, 8'd0, 16'd0, 16'd0};
                2: c = '{10'd1000, 10'd1000, 8'd255, 16'hFFFF, 16'hFFFF};
                3: c = '{10'd300, 10'd600, 8'd40, 16'd1000, 16'd20};
                4: c = '{10'd100, 10'd800, 8'd255, 16'd3000, 16'd8};   // dry bound below zero
                6: c = '{10'd450, 10'd450, 8'd10, 16'hFFFF, 16'd1};
                default: begin
                    c.dry_threshold        = $urandom_range(0, 1000);
                    c.damp_threshold       = $urandom_range(c.dry_threshold, 1000);
                    c.hyst_band            = $urandom_range(0, 255);
                    c.stale_limit_ms       = $urandom_range(100, 8000);
                    c.remote_timeout_ticks = $urandom_range(1, 60);
                end
            endcase
            program_regs(c);
            hum_walk = $urandom_range(0, 1000);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (p == 3 && n == 10) hold_req = 1'b1;   // receiver backs up, block fills
                if (p == 5 && n == 30) drain_results();
                send_tick(next_tick());
            end
            drain_results();
        end

        sb.close_out();
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
src/hlcr_pkg.sv
src/hlcr_cfg_regs.sv
src/hlcr_state.sv
src/humidity_level_color_ramp.sv
src/hlcr_checker.sv
verif/tb_top.sv
